// ===== rtl/dnsc_pkg.sv =====
// dnsc_pkg: constants for the dns udp packet classifier
// header offsets, ethertypes and defaults; no dependencies
`timescale 1ns / 1ps

package dnsc_pkg;

    localparam int QUEUE_COUNT_DEFAULT = 64;

    localparam logic [15:0] DEFAULT_PORT = 16'd53;
    localparam logic [15:0] KIND_IPV4    = 16'h0800;
    localparam logic [15:0] KIND_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [15:0] POS_KIND_HI  = 16'd12;
    localparam logic [15:0] POS_KIND_LO  = 16'd13;
    localparam logic [15:0] POS_IHL      = 16'd14;
    localparam logic [15:0] POS_IP4_PROTO = 16'd23;
    localparam logic [15:0] POS_IP6_PROTO = 16'd20;

    localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;
    localparam logic [6:0]  IP6_UDP_BASE = 7'd54;
    localparam logic [3:0]  IHL_MIN      = 4'd5;

    localparam logic [16:0] LEN_ETH_MIN  = 17'd14;
    localparam logic [16:0] LEN_IP4_MIN  = 17'd34;
    localparam logic [16:0] LEN_IP6_MIN  = 17'd54;
    localparam logic [16:0] UDP_HDR_LEN  = 17'd8;

endpackage

// ===== rtl/dns_udp_packet_classifier.sv =====
// dns_udp_packet_classifier: byte-wise ethernet/ipv4/ipv6/udp port filter
// verdict item is registered and valid in the cycle after the accepted last byte
// throughput: one byte item per cycle; ready drops only while a verdict is stalled
// reset (rst_n low, asynchronous): frame state cleared, match port back to 53
// depends on dnsc_pkg
`timescale 1ns / 1ps

module dns_udp_packet_classifier
    import dnsc_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] packet_byte
    input  logic        s_tlast,    // last_byte
    input  logic [5:0]  s_tuser,    // [5:0] queue_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] verdict, [6:1] target_queue, [7] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // [15:0] match_port
);

    logic [15:0] match_port_reg;
    logic [15:0] byte_position_reg;
    logic [15:0] ether_kind_reg;
    logic [3:0]  header_words_reg;
    logic [7:0]  next_protocol_reg;
    logic [15:0] source_port_reg;
    logic [15:0] dest_port_reg;
    logic        out_valid_reg;
    logic        verdict_reg;
    logic [5:0]  target_queue_reg;

    logic [15:0] ether_kind_next;
    logic [3:0]  header_words_next;
    logic [7:0]  next_protocol_next;
    logic [15:0] source_port_next;
    logic [15:0] dest_port_next;
    logic        verdict_next;

    logic        accept;
    logic        ip4;
    logic        ip6;
    logic [6:0]  cap_base;
    logic [15:0] pos;
    logic        v_ip4;
    logic        v_ip6;
    logic [6:0]  v_base;
    logic [16:0] frame_len;
    logic        frame_ok;
    logic        queue_ok;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, target_queue_reg, verdict_reg};

    // capture for the current byte
    always_comb
    begin
        pos                = byte_position_reg;
        ip4                = (ether_kind_reg == KIND_IPV4);
        ip6                = (ether_kind_reg == KIND_IPV6);
        ether_kind_next    = ether_kind_reg;
        header_words_next  = header_words_reg;
        next_protocol_next = next_protocol_reg;
        source_port_next   = source_port_reg;
        dest_port_next     = dest_port_reg;
        if (pos == POS_KIND_HI)
        begin
            ether_kind_next[15:8] = s_tdata;
        end
        if (pos == POS_KIND_LO)
        begin
            ether_kind_next[7:0] = s_tdata;
        end
        if (pos == POS_IHL)
        begin
            header_words_next = s_tdata[3:0];
        end
        if ((ip4 && pos == POS_IP4_PROTO) || (ip6 && pos == POS_IP6_PROTO))
        begin
            next_protocol_next = s_tdata;
        end
        cap_base = ip4 ? (ETH_HDR_LEN + {1'b0, header_words_next, 2'b00}) : IP6_UDP_BASE;
        if (ip4 || ip6)
        begin
            if (pos == {9'd0, cap_base})
            begin
                source_port_next[15:8] = s_tdata;
            end
            else if (pos == {9'd0, cap_base} + 16'd1)
            begin
                source_port_next[7:0] = s_tdata;
            end
            else if (pos == {9'd0, cap_base} + 16'd2)
            begin
                dest_port_next[15:8] = s_tdata;
            end
            else if (pos == {9'd0, cap_base} + 16'd3)
            begin
                dest_port_next[7:0] = s_tdata;
            end
        end
    end

    // verdict on the state after capture
    always_comb
    begin
        frame_len = {1'b0, byte_position_reg} + 17'd1;
        v_ip4     = (ether_kind_next == KIND_IPV4);
        v_ip6     = (ether_kind_next == KIND_IPV6);
        v_base    = v_ip4 ? (ETH_HDR_LEN + {1'b0, header_words_next, 2'b00}) : IP6_UDP_BASE;
        frame_ok  = 1'b0;
        if (frame_len >= LEN_ETH_MIN)
        begin
            if (v_ip4)
            begin
                frame_ok = (frame_len >= LEN_IP4_MIN) && (header_words_next >= IHL_MIN);
            end
            else if (v_ip6)
            begin
                frame_ok = (frame_len >= LEN_IP6_MIN);
            end
        end
        frame_ok = frame_ok && (next_protocol_next == PROTO_UDP)
                && (({10'd0, v_base} + UDP_HDR_LEN) <= frame_len)
                && ((source_port_next == match_port_reg) || (dest_port_next == match_port_reg));
        queue_ok     = ({3'd0, s_tuser} < 9'(QUEUE_COUNT));
        verdict_next = frame_ok && queue_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_port_reg    <= DEFAULT_PORT;
            byte_position_reg <= '0;
            ether_kind_reg    <= '0;
            header_words_reg  <= '0;
            next_protocol_reg <= '0;
            source_port_reg   <= '0;
            dest_port_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                match_port_reg <= cfg_data;
            end
            if (accept && s_tlast)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (s_tlast)
                begin
                    byte_position_reg <= '0;
                    ether_kind_reg    <= '0;
                    header_words_reg  <= '0;
                    next_protocol_reg <= '0;
                    source_port_reg   <= '0;
                    dest_port_reg     <= '0;
                end
                else
                begin
                    if (byte_position_reg != 16'hFFFF)
                    begin
                        byte_position_reg <= byte_position_reg + 16'd1;
                    end
                    ether_kind_reg    <= ether_kind_next;
                    header_words_reg  <= header_words_next;
                    next_protocol_reg <= next_protocol_next;
                    source_port_reg   <= source_port_next;
                    dest_port_reg     <= dest_port_next;
                end
            end
        end
    end

    // result payload, loaded with its valid
    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            verdict_reg      <= verdict_next;
            target_queue_reg <= verdict_next ? s_tuser : 6'd0;
        end
    end

endmodule

// ===== rtl/dnsc_checker.sv =====
// dnsc_checker: port-level assertions for dns_udp_packet_classifier
// bound to the top level below; depends on dnsc_pkg
`timescale 1ns / 1ps

module dnsc_checker
    import dnsc_pkg::*;
#(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEFAULT
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic [5:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // a last byte always gives a verdict item next cycle
    a_last_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no verdict after last byte");

    // a non-last byte never makes an item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !(m_tvalid && !m_tready) |=> !m_tvalid)
        else $error("verdict without last byte");

    // out of range queue is always dropped with a zero target
    a_bad_queue_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && ({3'd0, s_tuser} >= 9'(QUEUE_COUNT))
        |=> m_tdata[6:0] == 7'd0)
        else $error("redirect to missing queue");

endmodule

bind dns_udp_packet_classifier dnsc_checker #(.QUEUE_COUNT(QUEUE_COUNT)) u_dnsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
